/* sv/lsbf_pkg.sv */
// Package for the linear-scan best-fit allocator.
// Sizes, transfer structs, store entry types and the controller command codes.
// No dependencies.
package lsbf_pkg;

  // Store depths and alignment (alignment is a power of two)
  localparam int ACTIVE_SLOTS = 32;
  localparam int FREE_SLOTS   = 32;
  localparam int ALIGN_LOG2   = 6;
  localparam int ALIGN_BYTES  = 1 << ALIGN_LOG2;

  localparam int AIDX_W = $clog2(ACTIVE_SLOTS);
  localparam int ACNT_W = $clog2(ACTIVE_SLOTS + 1);
  localparam int FIDX_W = $clog2(FREE_SLOTS);
  localparam int FCNT_W = $clog2(FREE_SLOTS + 1);

  localparam int ADDR_W = 33;   // block address, one bit above the pool range
  localparam int SIZE_W = 25;   // aligned size, up to 2^24

  // Status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FREE_FULL = 2'd1;
  localparam logic [1:0] ST_ACT_FULL  = 2'd2;
  localparam logic [1:0] ST_OVERFLOW  = 2'd3;

  typedef struct packed {
    logic        first_of_program;
    logic [15:0] start_time;
    logic [15:0] end_time;
    logic [23:0] raw_size;
  } in_item_t;

  typedef struct packed {
    logic [31:0] address;
    logic        reused;
    logic [31:0] peak_bytes;
    logic [1:0]  status;
  } out_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [SIZE_W-1:0] size;
  } blk_t;

  typedef struct packed {
    logic [15:0] end_time;
    blk_t        blk;
  } act_entry_t;

  // Datapath commands from the controller
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_EXP_RD,
    CMD_EXP_CHK,
    CMD_EXP_END,
    CMD_FIT_RD,
    CMD_FIT_CHK,
    CMD_TAKE,
    CMD_SHIFT_RD,
    CMD_SHIFT_WR,
    CMD_SHIFT_END,
    CMD_INS_CHECK,
    CMD_INS_RD,
    CMD_INS_MOVE,
    CMD_INS_PUT,
    CMD_EMIT
  } cmd_t;

  // Datapath status toward the controller
  typedef struct packed {
    logic exp_more;    // active entries left to check for expiry
    logic fit_more;    // free entries left to scan
    logic found;       // a fitting free block was found
    logic tail_keep;   // the leftover tail stays in the free slot
    logic overflow;    // bump allocation would run past the pool end
    logic shift_more;  // free entries left to close the gap
    logic act_full;    // no room in the active list
    logic ins_more;    // entries left below the insert point
    logic ins_move;    // entry read must move up one slot
    logic out_free;    // output register can take a result
  } dp_status_t;

endpackage

/* sv/lsbf_ctrl.sv */
// Controller state machine for the allocator.
// Sequences expiry, best-fit scan, gap closing and sorted insert. Uses lsbf_pkg.
module lsbf_ctrl import lsbf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t stat,
  output cmd_t       cmd
);

  typedef enum logic [12:0] {
    S_IDLE     = 13'b0000000000001,
    S_EXP_RD   = 13'b0000000000010,
    S_EXP_CHK  = 13'b0000000000100,
    S_FIT_RD   = 13'b0000000001000,
    S_FIT_CHK  = 13'b0000000010000,
    S_TAKE     = 13'b0000000100000,
    S_SHIFT_RD = 13'b0000001000000,
    S_SHIFT_WR = 13'b0000010000000,
    S_INS      = 13'b0000100000000,
    S_INS_RD   = 13'b0001000000000,
    S_INS_CHK  = 13'b0010000000000,
    S_DONE     = 13'b0100000000000,
    S_FIT_INIT = 13'b1000000000000
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);

  // Next state and command
  always_comb begin
    state_next = state;
    cmd        = CMD_NONE;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd        = CMD_LOAD;
          state_next = S_EXP_RD;
        end
      end
      S_EXP_RD: begin
        if (stat.exp_more) begin
          cmd        = CMD_EXP_RD;
          state_next = S_EXP_CHK;
        end else begin
          cmd        = CMD_EXP_END;
          state_next = S_FIT_INIT;
        end
      end
      S_EXP_CHK: begin
        cmd        = CMD_EXP_CHK;
        state_next = S_EXP_RD;
      end
      S_FIT_INIT: begin
        state_next = S_FIT_RD;
      end
      S_FIT_RD: begin
        if (stat.fit_more) begin
          cmd        = CMD_FIT_RD;
          state_next = S_FIT_CHK;
        end else begin
          state_next = S_TAKE;
        end
      end
      S_FIT_CHK: begin
        cmd        = CMD_FIT_CHK;
        state_next = S_FIT_RD;
      end
      S_TAKE: begin
        cmd = CMD_TAKE;
        priority if (stat.found && !stat.tail_keep) state_next = S_SHIFT_RD;
        else if (!stat.found && stat.overflow)      state_next = S_DONE;
        else                                         state_next = S_INS;
      end
      S_SHIFT_RD: begin
        if (stat.shift_more) begin
          cmd        = CMD_SHIFT_RD;
          state_next = S_SHIFT_WR;
        end else begin
          cmd        = CMD_SHIFT_END;
          state_next = S_INS;
        end
      end
      S_SHIFT_WR: begin
        cmd        = CMD_SHIFT_WR;
        state_next = S_SHIFT_RD;
      end
      S_INS: begin
        cmd        = CMD_INS_CHECK;
        state_next = stat.act_full ? S_DONE : S_INS_RD;
      end
      S_INS_RD: begin
        if (stat.ins_more) begin
          cmd        = CMD_INS_RD;
          state_next = S_INS_CHK;
        end else begin
          cmd        = CMD_INS_PUT;
          state_next = S_DONE;
        end
      end
      S_INS_CHK: begin
        if (stat.ins_move) begin
          cmd        = CMD_INS_MOVE;
          state_next = S_INS_RD;
        end else begin
          cmd        = CMD_INS_PUT;
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd        = CMD_EMIT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* sv/lsbf_datapath.sv */
// Datapath for the allocator: active and free stores, counters, bump pointer,
// best-fit tracking and the output register. Uses lsbf_pkg.
module lsbf_datapath import lsbf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output dp_status_t  stat,
  input  in_item_t    in_item,
  input  logic        cfg_valid,
  input  logic [31:0] cfg_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_item
);

  // Stores
  act_entry_t act_mem [ACTIVE_SLOTS];
  blk_t       free_mem [FREE_SLOTS];
  act_entry_t act_rdata;
  blk_t       free_rdata;

  // Control state
  logic [31:0]       base_address;
  logic [ACNT_W-1:0] active_count, aidx, keep;
  logic [FCNT_W-1:0] free_count, fidx;
  logic [ADDR_W-1:0] bump_pointer, high_water;
  logic              found, reused;
  logic [1:0]        status;

  // Item payload
  logic [15:0]       now, fin;
  logic [SIZE_W-1:0] need;
  logic [FIDX_W-1:0] best;
  blk_t              best_blk;
  logic [ADDR_W-1:0] addr;

  logic [SIZE_W-1:0] need_in;
  logic [SIZE_W-1:0] rem;
  logic [ADDR_W:0]   bump_sum;
  logic [ADDR_W-1:0] bump_start, hw_start;
  logic [ADDR_W-1:0] peak_diff;
  logic [31:0]       peak;
  logic              fit_hit;

  // Round the raw size up to the alignment
  assign need_in = ((SIZE_W'(in_item.raw_size) + SIZE_W'(ALIGN_BYTES - 1)) >> ALIGN_LOG2)
                   << ALIGN_LOG2;

  assign rem      = best_blk.size - need;
  assign bump_sum = {1'b0, bump_pointer} + (ADDR_W + 1)'(need);
  assign fit_hit  = (free_rdata.size >= need) && (!found || free_rdata.size < best_blk.size);

  // Pointers as seen at load time (a first item restarts the pool)
  assign bump_start = {1'b0, base_address};
  assign hw_start   = {1'b0, base_address};

  // Peak relative to the current base, clipped at both ends
  assign peak_diff = high_water - {1'b0, base_address};
  always_comb begin
    if (high_water <= {1'b0, base_address}) begin
      peak = '0;
    end else if (peak_diff[ADDR_W-1]) begin
      peak = '1;
    end else begin
      peak = peak_diff[31:0];
    end
  end

  // Status toward the controller
  always_comb begin
    stat.exp_more   = aidx < active_count;
    stat.fit_more   = fidx < free_count;
    stat.found      = found;
    stat.tail_keep  = rem >= SIZE_W'(ALIGN_BYTES);
    stat.overflow   = bump_sum > (ADDR_W + 1)'(64'h1_0000_0000);
    stat.shift_more = (fidx + 1'b1) < free_count;
    stat.act_full   = active_count >= ACNT_W'(ACTIVE_SLOTS);
    stat.ins_more   = aidx != '0;
    stat.ins_move   = act_rdata.end_time >= fin;
    stat.out_free   = !out_valid || out_ready;
  end

  // Active store port control
  logic              act_we;
  logic [AIDX_W-1:0] act_wa, act_ra;
  act_entry_t        act_wd;
  always_comb begin
    act_we = 1'b0;
    act_wa = aidx[AIDX_W-1:0];
    act_wd = act_rdata;
    act_ra = aidx[AIDX_W-1:0];
    unique case (cmd)
      CMD_EXP_CHK: begin
        act_we = act_rdata.end_time >= now;
        act_wa = keep[AIDX_W-1:0];
      end
      CMD_INS_RD:   act_ra = AIDX_W'(aidx - 1'b1);
      CMD_INS_MOVE: act_we = 1'b1;
      CMD_INS_PUT: begin
        act_we = 1'b1;
        act_wd = '{end_time: fin, blk: '{addr: addr, size: need}};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (act_we) begin
      act_mem[act_wa] <= act_wd;
    end
    act_rdata <= act_mem[act_ra];
  end

  // Free store port control
  logic              free_we;
  logic [FIDX_W-1:0] free_wa, free_ra;
  blk_t              free_wd;
  always_comb begin
    free_we = 1'b0;
    free_wa = fidx[FIDX_W-1:0];
    free_wd = free_rdata;
    free_ra = fidx[FIDX_W-1:0];
    unique case (cmd)
      CMD_EXP_CHK: begin
        free_we = (act_rdata.end_time < now) && (free_count < FCNT_W'(FREE_SLOTS));
        free_wa = free_count[FIDX_W-1:0];
        free_wd = act_rdata.blk;
      end
      CMD_TAKE: begin
        free_we = found && stat.tail_keep;
        free_wa = best;
        free_wd = '{addr: best_blk.addr + ADDR_W'(need), size: rem};
      end
      CMD_SHIFT_RD: free_ra = FIDX_W'(fidx + 1'b1);
      CMD_SHIFT_WR: free_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (free_we) begin
      free_mem[free_wa] <= free_wd;
    end
    free_rdata <= free_mem[free_ra];
  end

  // Item payload registers
  always_ff @(posedge clk) begin
    unique case (cmd)
      CMD_LOAD: begin
        now  <= in_item.start_time;
        fin  <= in_item.end_time;
        need <= need_in;
        addr <= '0;
      end
      CMD_FIT_CHK: begin
        if (fit_hit) begin
          best     <= fidx[FIDX_W-1:0];
          best_blk <= free_rdata;
        end
      end
      CMD_TAKE: begin
        if (found) begin
          addr <= best_blk.addr;
        end else if (!stat.overflow) begin
          addr <= bump_pointer;
        end
      end
      default: ;
    endcase
  end

  // Counters, pointers and flags
  always_ff @(posedge clk) begin
    if (rst) begin
      base_address <= '0;
      active_count <= '0;
      free_count   <= '0;
      bump_pointer <= '0;
      high_water   <= '0;
      aidx         <= '0;
      keep         <= '0;
      fidx         <= '0;
      found        <= 1'b0;
      reused       <= 1'b0;
      status       <= ST_OK;
    end else begin
      if (cfg_valid) begin
        base_address <= cfg_data;
      end
      unique case (cmd)
        CMD_LOAD: begin
          if (in_item.first_of_program) begin
            active_count <= '0;
            free_count   <= '0;
            bump_pointer <= bump_start;
            high_water   <= hw_start;
          end
          aidx   <= '0;
          keep   <= '0;
          found  <= 1'b0;
          reused <= 1'b0;
          status <= ST_OK;
        end
        CMD_EXP_CHK: begin
          if (act_rdata.end_time < now) begin
            if (free_count < FCNT_W'(FREE_SLOTS)) begin
              free_count <= free_count + 1'b1;
            end else if (status == ST_OK) begin
              status <= ST_FREE_FULL;
            end
          end else begin
            keep <= keep + 1'b1;
          end
          aidx <= aidx + 1'b1;
        end
        CMD_EXP_END: begin
          active_count <= keep;
          fidx         <= '0;
        end
        CMD_FIT_CHK: begin
          if (fit_hit) begin
            found <= 1'b1;
          end
          fidx <= fidx + 1'b1;
        end
        CMD_TAKE: begin
          if (found) begin
            reused <= 1'b1;
            fidx   <= FCNT_W'(best);
          end else if (stat.overflow) begin
            status <= ST_OVERFLOW;
          end else begin
            bump_pointer <= bump_sum[ADDR_W-1:0];
            if (bump_sum[ADDR_W-1:0] > high_water) begin
              high_water <= bump_sum[ADDR_W-1:0];
            end
          end
        end
        CMD_SHIFT_WR:  fidx <= fidx + 1'b1;
        CMD_SHIFT_END: free_count <= free_count - 1'b1;
        CMD_INS_CHECK: begin
          aidx <= active_count;
          if (stat.act_full) begin
            status <= ST_ACT_FULL;
          end
        end
        CMD_INS_MOVE: aidx <= aidx - 1'b1;
        CMD_INS_PUT:  active_count <= active_count + 1'b1;
        default: ;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd == CMD_EMIT) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd == CMD_EMIT) begin
      out_item <= '{address: addr[31:0], reused: reused, peak_bytes: peak, status: status};
    end
  end

endmodule

/* sv/linear_scan_best_fit_allocator_top.sv */
// Top level of the linear-scan best-fit allocator.
// Joins lsbf_ctrl and lsbf_datapath. Uses lsbf_pkg.
//
// Usage: intervals arrive on in_valid/in_ready as in_item, in nondecreasing
// start order; each gives exactly one result on out_valid/out_ready as
// out_item (address, reused flag, peak bytes, status). The pool base is
// written through cfg_valid/cfg_data; the user must write it only while
// the block is idle (not enforced by the block); cfg_ready is always high.
// One item is worked at a time: the controller checks the active entries
// for expiry, scans the free entries for the best fit, moves free entries
// down to close a consumed slot, and moves active entries up for the sorted
// insert; an address overflow or a full active list skips the insert.
// The controller returns to its idle state after each result before the
// next transfer is accepted. Each store has one read and one write port
// with a registered read, so each entry visit takes a read state and then a
// check or write state. Reset empties both lists and sets the base, bump
// pointer and peak to zero; no clearing pass is needed. A result waits in
// the output register while the receiver stalls; the next item may be
// accepted and worked meanwhile, and it holds in its last state until the
// register frees.
module linear_scan_best_fit_allocator_top import lsbf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_item,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_item,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  cmd_t       cmd;
  dp_status_t stat;

  assign cfg_ready = 1'b1;

  // Sequencer
  lsbf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Stores and arithmetic
  lsbf_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_item   (in_item),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

/* tb/linear_scan_best_fit_allocator_top_test.sv */
// Testbench for the linear-scan best-fit allocator top level.
// Drives intervals with random idling, predicts each result with a scoreboard
// class holding its own allocator state; depends on lsbf_pkg and the RTL top.
`timescale 1ns / 1ps

module linear_scan_best_fit_allocator_top_test;
  import lsbf_pkg::*;

  // Predictor of allocator behavior plus a queue of expected results
  class alloc_scoreboard;
    logic [31:0] base;
    logic [15:0] act_end [ACTIVE_SLOTS];
    logic [32:0] act_addr [ACTIVE_SLOTS];
    logic [32:0] act_size [ACTIVE_SLOTS];
    int          act_cnt;
    logic [32:0] fr_addr [FREE_SLOTS];
    logic [32:0] fr_size [FREE_SLOTS];
    int          fr_cnt;
    logic [32:0] bump;
    logic [32:0] high;
    out_item_t   pending [$];
    int          mismatches;

    function new();
      base = 0;
      mismatches = 0;
      clear_pool();
    endfunction

    function void clear_pool();
      act_cnt = 0;
      fr_cnt = 0;
      bump = {1'b0, base};
      high = {1'b0, base};
    endfunction

    function void set_base(logic [31:0] v);
      base = v;
    endfunction

    // Work out the result of one accepted interval
    function void note_input(in_item_t it);
      logic [32:0] need, rem;
      logic [1:0]  st;
      logic [32:0] addr;
      logic        reused, placed, found;
      int          keep, best, pos;
      logic [32:0] peak;
      out_item_t   r;
      st = ST_OK;
      addr = 0;
      reused = 0;
      placed = 1;
      found = 0;
      best = 0;
      need = ((33'(it.raw_size) + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
      if (it.first_of_program) clear_pool();
      // expiry, in active-list order
      keep = 0;
      for (int i = 0; i < act_cnt; i++) begin
        if (act_end[i] < it.start_time) begin
          if (fr_cnt < FREE_SLOTS) begin
            fr_addr[fr_cnt] = act_addr[i];
            fr_size[fr_cnt] = act_size[i];
            fr_cnt++;
          end else if (st < ST_FREE_FULL) st = ST_FREE_FULL;
        end else begin
          act_end[keep] = act_end[i];
          act_addr[keep] = act_addr[i];
          act_size[keep] = act_size[i];
          keep++;
        end
      end
      act_cnt = keep;
      // best fit, earliest on ties
      for (int i = 0; i < fr_cnt; i++)
        if (fr_size[i] >= need && (!found || fr_size[i] < fr_size[best])) begin
          best = i;
          found = 1;
        end
      if (found) begin
        rem = fr_size[best] - need;
        addr = fr_addr[best];
        reused = 1;
        if (rem >= ALIGN_BYTES) begin
          fr_addr[best] = addr + need;
          fr_size[best] = rem;
        end else begin
          for (int i = best; i + 1 < fr_cnt; i++) begin
            fr_addr[i] = fr_addr[i+1];
            fr_size[i] = fr_size[i+1];
          end
          fr_cnt--;
        end
      end else if ({1'b0, bump} + {1'b0, need} > 34'h1_0000_0000) begin
        placed = 0;
        st = ST_OVERFLOW;
        addr = 0;
      end else begin
        addr = bump;
        bump = bump + need;
        if (bump > high) high = bump;
      end
      // sorted insert, newer first on ties
      if (placed) begin
        if (act_cnt >= ACTIVE_SLOTS) begin
          if (st < ST_ACT_FULL) st = ST_ACT_FULL;
        end else begin
          pos = 0;
          while (pos < act_cnt && act_end[pos] < it.end_time) pos++;
          for (int i = act_cnt; i > pos; i--) begin
            act_end[i] = act_end[i-1];
            act_addr[i] = act_addr[i-1];
            act_size[i] = act_size[i-1];
          end
          act_end[pos] = it.end_time;
          act_addr[pos] = addr;
          act_size[pos] = need;
          act_cnt++;
        end
      end
      peak = (high > {1'b0, base}) ? high - {1'b0, base} : 33'd0;
      r.address = addr[31:0];
      r.reused = reused;
      r.peak_bytes = peak[32] ? 32'hFFFF_FFFF : peak[31:0];
      r.status = st;
      pending = {pending, r};
    endfunction

    function void check_result(out_item_t got);
      out_item_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
        return;
      end
      e = pending.pop_front();
      if (got.address !== e.address || got.reused !== e.reused ||
          got.peak_bytes !== e.peak_bytes || got.status !== e.status) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp addr %h reused %b peak %h status %0d, got %h %b %h %0d",
                   e.address, e.reused, e.peak_bytes, e.status,
                   got.address, got.reused, got.peak_bytes, got.status);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_item;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_item;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [31:0] cfg_data;

  alloc_scoreboard sb;
  logic            calm;     // no-idle stretch
  logic [15:0]     now_t;

  linear_scan_best_fit_allocator_top u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // Timeout
  initial begin
    #40_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic logic idle_now();
    return !calm && ($urandom_range(99) < 23);
  endfunction

  // Receiver: random stall, check each transfer
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 0;
    end else begin
      if (out_valid && out_ready) sb.check_result(out_item);
      out_ready <= !idle_now();
    end
  end

  task automatic send_item(logic fp, logic [15:0] st, logic [15:0] et, logic [23:0] sz);
    in_item_t it;
    it.first_of_program = fp;
    it.start_time = st;
    it.end_time = et;
    it.raw_size = sz;
    while (idle_now()) @(posedge clk);
    in_valid <= 1;
    in_item <= it;
    do @(posedge clk); while (!in_ready);
    sb.note_input(it);
    in_valid <= 0;
    @(posedge clk);
  endtask

  task automatic write_base(logic [31:0] v);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    cfg_valid <= 1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.set_base(v);
    cfg_valid <= 0;
  endtask

  // Random well-formed program with random lifetimes
  task automatic run_program(int n, int max_sz, int max_life);
    logic [15:0] et;
    now_t = 16'($urandom_range(3));
    for (int i = 0; i < n; i++) begin
      if (i > 0 && $urandom_range(99) < 70) now_t = 16'(now_t + $urandom_range(3));
      if ($urandom_range(99) < 5) et = 16'($urandom);
      else if ($urandom_range(99) < 5) et = 16'(now_t - 1);
      else et = 16'(now_t + $urandom_range(max_life));
      send_item(i == 0, now_t, et, 24'($urandom_range(max_sz)));
    end
  endtask

  initial begin
    sb = new();
    rst = 1;
    in_valid = 0;
    in_item = '0;
    cfg_valid = 0;
    cfg_data = 0;
    calm = 0;
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: extremes, zero size, expiry, reuse, tail keep
    send_item(1'b1, 16'd0, 16'd0, 24'd0);
    send_item(1'b0, 16'd0, 16'd5, 24'd1);
    send_item(1'b0, 16'd0, 16'd3, 24'd200);
    send_item(1'b0, 16'd4, 16'd9, 24'd64);
    send_item(1'b0, 16'd6, 16'd9, 24'd100);
    send_item(1'b0, 16'd10, 16'd65535, 24'hFFFFFF);
    send_item(1'b0, 16'd65535, 16'd65535, 24'hFFFFFF);
    send_item(1'b0, 16'd5, 16'd2, 24'd65);
    // active list overflow: 34 long-lived items
    send_item(1'b1, 16'd0, 16'd65535, 24'd64);
    for (int i = 0; i < 33; i++)
      send_item(1'b0, 16'd0, 16'hFFFF, 24'($urandom_range(1, 128)));
    // address overflow near top of pool
    write_base(32'hFF00_0000);
    send_item(1'b1, 16'd0, 16'd1, 24'hFFFFFF);
    send_item(1'b0, 16'd0, 16'd1, 24'hFFFFFF);
    send_item(1'b0, 16'd0, 16'd1, 24'hFFFFFF);

    // Random programs across several bases
    write_base(32'h0000_0000);
    run_program(100, 300, 8);
    calm = 1;
    run_program(100, 4000, 20);
    calm = 0;
    write_base(32'hFFFF_FFFF);
    run_program(20, 100, 4);
    write_base($urandom);
    run_program(150, 24'hFFFFFF, 10);
    // lower base without first flag: peak may go below base
    write_base(32'h8000_0000);
    send_item(1'b0, now_t, now_t, 24'd10);
    write_base(32'h0000_1000);
    for (int k = 0; k < 8; k++) run_program(50, (k % 2) ? 2000 : 24'hFFFFFF, 40);

    // Drain
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
